/* rtl/blpd_pkg.sv */
package blpd_pkg;

    localparam logic [7:0] CH_SOH    = 8'h01;
    localparam logic [7:0] CH_ETX    = 8'h03;
    localparam logic [7:0] CTRL_TOP  = 8'd31;
    localparam logic [7:0] TYPE_WRAP = 8'h31;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [3:0] RADIX     = 4'd10;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOSOH = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    localparam logic [2:0] FMT_LE16  = 3'd0;
    localparam logic [2:0] FMT_LE32  = 3'd1;
    localparam logic [2:0] FMT_BE32  = 3'd2;
    localparam logic [2:0] FMT_BE24  = 3'd3;
    localparam logic [2:0] FMT_ASCII = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        first_of_record;
        logic        is_header;
        logic [7:0]  header_char;
        logic        last_of_record;
        logic [1:0]  status;
        logic [32:0] record_length;
    } t_out_item;

    // result kinds the datapath knows how to build
    typedef enum logic [2:0] {
        K_ERROR = 3'd0,
        K_SOH   = 3'd1,
        K_HOLD  = 3'd2,
        K_BYTE  = 3'd3,
        K_ETX   = 3'd4
    } t_kind;

    // controller to datapath
    typedef struct packed {
        logic       take;       // latch input item
        logic       prefix;     // fold byte into length prefix
        logic       payload;    // payload byte bookkeeping
        logic       emit;       // drive a result into the output register
        t_kind      kind;
        logic [1:0] status;
        logic       clr_halt;
    } t_cmd;

endpackage

/* rtl/blpd_datapath.sv */
module blpd_datapath #(
    parameter int HEADER_OFFSET = 10,
    parameter int MAX_HEADER    = 25,
    localparam int IW = $clog2(HEADER_OFFSET + 2),
    localparam int HW = $clog2(MAX_HEADER + 1),
    localparam int RW = $clog2(HEADER_OFFSET + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [2:0]          i_fmt,
    input  blpd_pkg::t_in_item  i_item,
    input  blpd_pkg::t_cmd      i_cmd,
    input  logic [RW-1:0]       i_rd_idx,
    output logic [7:0]          o_byte,
    output logic                o_eof,
    output logic                o_prefix_done,
    output logic                o_len_zero,
    output logic                o_wrap,
    output logic [IW-1:0]       o_idx,
    output logic                o_hdr,
    output logic                o_done,
    output blpd_pkg::t_out_item o_res
);
    localparam int HOLD = HEADER_OFFSET + 1;

    logic [7:0]    r_byte;
    logic          r_eof;
    logic [3:0]    r_pcnt;
    logic [31:0]   r_acc;
    logic [31:0]   r_left;
    logic [IW-1:0] r_idx;
    logic [HW-1:0] r_hcnt;
    logic          r_hend;
    logic          r_wrap;
    logic [1:0]    r_dig;
    logic [7:0]    r_hold [HOLD];
    logic [7:0]    r_rd;
    logic          r_first;

    logic [31:0] n_acc;
    logic        n_wrap;
    logic [1:0]  n_dig;
    logic [3:0]  plen;
    logic [31:0] acc0;
    logic [1:0]  dig0;
    logic [31:0] left_dec;
    logic [32:0] rlen;
    blpd_pkg::t_out_item n_res;

    always_comb begin
        case (i_fmt)
            blpd_pkg::FMT_LE16:  plen = 4'd2;
            blpd_pkg::FMT_ASCII: plen = 4'd10;
            default:             plen = 4'd4;
        endcase
    end

    // prefix accumulate for the latched byte
    always_comb begin
        acc0   = (r_pcnt == 4'd0) ? 32'd0 : r_acc;
        dig0   = (r_pcnt == 4'd0) ? 2'd0 : r_dig;
        n_wrap = (r_pcnt == 4'd0) ? 1'b0 : r_wrap;
        n_dig  = dig0;
        n_acc  = acc0;
        case (i_fmt)
            blpd_pkg::FMT_LE16, blpd_pkg::FMT_LE32: begin
                if (r_pcnt < 4'd4) begin
                    n_acc = acc0 | ({24'd0, r_byte} << {r_pcnt[1:0], 3'b000});
                end
            end
            blpd_pkg::FMT_BE32: n_acc = {acc0[23:0], r_byte};
            blpd_pkg::FMT_BE24: begin
                if (r_pcnt != 4'd0) begin
                    n_acc = {acc0[23:0], r_byte};
                end
            end
            default: begin
                if (r_pcnt < 4'd8) begin
                    if (dig0 == 2'd0 && r_byte == blpd_pkg::CH_SPACE) begin
                        n_dig = dig0;
                    end else if (dig0 < 2'd2 && r_byte >= blpd_pkg::CH_ZERO
                                 && r_byte <= blpd_pkg::CH_NINE) begin
                        n_acc = (acc0 << 3) + (acc0 << 1)
                              + {28'd0, 4'(r_byte - blpd_pkg::CH_ZERO)};
                        n_dig = 2'd1;
                    end else begin
                        n_dig = 2'd2;
                    end
                end else if (r_pcnt == 4'd9) begin
                    n_wrap = (r_byte == blpd_pkg::TYPE_WRAP);
                end
            end
        endcase
    end

    assign o_prefix_done = (4'(r_pcnt + 4'd1) >= plen);
    assign o_len_zero    = (n_acc == 32'd0);
    assign o_byte        = r_byte;
    assign o_eof         = r_eof;
    assign o_wrap        = r_wrap;
    assign o_idx         = r_idx;
    assign o_hdr = (r_idx >= IW'(HEADER_OFFSET)) && !r_hend
                && (r_hcnt < HW'(MAX_HEADER)) && (r_byte > blpd_pkg::CTRL_TOP);
    assign left_dec = (r_left != 32'd0) ? r_left - 32'd1 : 32'd0;
    assign o_done   = (left_dec == 32'd0);
    assign rlen     = {1'b0, r_acc} + (r_wrap ? 33'd2 : 33'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= '0;
            r_acc  <= '0;
            r_left <= '0;
            r_idx  <= '0;
            r_hcnt <= '0;
            r_hend <= 1'b0;
            r_wrap <= 1'b0;
            r_dig  <= '0;
            r_eof  <= 1'b0;
            r_first <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_byte <= i_item.in_byte;
                r_eof  <= i_item.end_of_file;
            end
            if (i_cmd.clr_halt) begin
                r_pcnt <= '0;
            end
            if (i_cmd.prefix) begin
                r_acc  <= n_acc;
                r_dig  <= n_dig;
                r_wrap <= n_wrap;
                if (o_prefix_done) begin
                    r_pcnt <= '0;
                    r_left <= n_acc;
                    r_idx  <= '0;
                    r_hcnt <= '0;
                    r_hend <= 1'b0;
                end else begin
                    r_pcnt <= 4'(r_pcnt + 4'd1);
                end
            end
            if (i_cmd.payload) begin
                r_left <= left_dec;
                if (r_idx >= IW'(HEADER_OFFSET) && !r_hend
                    && r_hcnt < HW'(MAX_HEADER)) begin
                    if (r_byte > blpd_pkg::CTRL_TOP) begin
                        r_hcnt <= HW'(r_hcnt + 1'b1);
                    end else begin
                        r_hend <= 1'b1;
                    end
                end
                if (r_idx < IW'(HEADER_OFFSET)) begin
                    r_hold[r_idx[RW-1:0]] <= r_byte;
                    r_idx <= IW'(r_idx + 1'b1);
                end else if (r_idx == IW'(HEADER_OFFSET)) begin
                    r_idx <= IW'(HOLD);
                end
            end
            r_rd <= r_hold[i_rd_idx];
            if (i_cmd.prefix && o_prefix_done) begin
                r_first <= 1'b1;
            end else if (i_cmd.emit) begin
                r_first <= (i_cmd.kind == blpd_pkg::K_ERROR);
            end
        end
    end

    // result item for the current command
    always_comb begin
        n_res = '0;
        n_res.first_of_record = r_first;
        case (i_cmd.kind)
            blpd_pkg::K_ERROR: begin
                n_res.first_of_record = 1'b0;
                n_res.last_of_record  = 1'b1;
                n_res.status          = i_cmd.status;
            end
            blpd_pkg::K_SOH: begin
                n_res.out_valid = 1'b1;
                n_res.out_byte  = blpd_pkg::CH_SOH;
            end
            blpd_pkg::K_HOLD: begin
                n_res.out_valid = 1'b1;
                n_res.out_byte  = r_rd;
            end
            blpd_pkg::K_BYTE: begin
                n_res.out_valid = 1'b1;
                n_res.out_byte  = r_byte;
                n_res.is_header = o_hdr;
                n_res.header_char = !o_hdr ? 8'd0 :
                    (r_byte == blpd_pkg::CH_SPACE ? blpd_pkg::CH_UNDER : r_byte);
                if (o_done && !r_wrap) begin
                    n_res.last_of_record = 1'b1;
                    n_res.record_length  = rlen;
                end
            end
            blpd_pkg::K_ETX: begin
                n_res.first_of_record = 1'b0;
                n_res.out_valid      = 1'b1;
                n_res.out_byte       = blpd_pkg::CH_ETX;
                n_res.last_of_record = 1'b1;
                n_res.record_length  = rlen;
            end
            default: n_res = '0;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_res <= n_res;
        end
    end
endmodule

/* rtl/blpd_ctrl.sv */
module blpd_ctrl #(
    parameter int HEADER_OFFSET = 10,
    localparam int IW = $clog2(HEADER_OFFSET + 2),
    localparam int RW = $clog2(HEADER_OFFSET + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [2:0]     i_fmt,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  logic [7:0]     i_byte,
    input  logic           i_eof,
    input  logic           i_prefix_done,
    input  logic           i_len_zero,
    input  logic           i_wrap,
    input  logic [IW-1:0]  i_idx,
    input  logic           i_hdr,
    input  logic           i_done,
    output blpd_pkg::t_cmd o_cmd,
    output logic [RW-1:0]  o_rd_idx
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_FLUSH = 6'b000100,
        S_BYTE  = 6'b001000,
        S_ETX   = 6'b010000,
        S_ERR   = 6'b100000
    } t_state;

    // record phase
    typedef enum logic [2:0] {
        P_PREFIX  = 3'b001,
        P_PAYLOAD = 3'b010,
        P_PAD     = 3'b100
    } t_phase;

    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic          r_halt, n_halt;
    logic          r_ov, n_ov;
    logic [RW-1:0] r_cnt, n_cnt;
    logic          r_soh, n_soh;
    logic [1:0]    r_est, n_est;
    logic          r_eend, n_eend;
    logic          emit_ok;
    // a fresh prefix begins when no prefix byte has been taken yet
    logic          r_first_prefix;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign emit_ok     = !r_ov || !i_out_stall;
    assign o_rd_idx    = n_cnt;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_halt  = r_halt;
        n_ov    = r_ov && i_out_stall;
        n_cnt   = r_cnt;
        n_soh   = r_soh;
        n_est   = r_est;
        n_eend  = r_eend;
        o_cmd   = '0;
        o_cmd.kind = blpd_pkg::K_ERROR;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                if (r_halt) begin
                    if (i_eof) begin
                        n_halt = 1'b0;
                        n_phase = P_PREFIX;
                        o_cmd.clr_halt = 1'b1;
                    end
                end else if (r_phase == P_PAD) begin
                    n_phase = P_PREFIX;
                    o_cmd.clr_halt = 1'b1;
                end else if (r_phase == P_PREFIX) begin
                    if (i_fmt > blpd_pkg::FMT_ASCII && r_first_prefix) begin
                        n_halt = !i_eof;
                    end else begin
                        o_cmd.prefix = 1'b1;
                        if (!i_prefix_done) begin
                            if (i_eof) begin
                                n_est = blpd_pkg::ST_TRUNC; n_eend = 1'b1;
                                n_state = S_ERR;
                            end
                        end else if (i_len_zero) begin
                            if (i_fmt != blpd_pkg::FMT_ASCII) begin
                                n_est = blpd_pkg::ST_NOSOH; n_eend = i_eof;
                                n_state = S_ERR;
                            end
                        end else begin
                            n_phase = P_PAYLOAD;
                            if (i_eof) begin
                                n_est = blpd_pkg::ST_TRUNC; n_eend = 1'b1;
                                n_state = S_ERR;
                            end
                        end
                    end
                end else begin
                    if (i_idx == '0 && !i_wrap && i_byte != blpd_pkg::CH_SOH) begin
                        n_est = blpd_pkg::ST_NOSOH; n_eend = i_eof; n_state = S_ERR;
                    end else if (i_idx == IW'(HEADER_OFFSET) && !i_hdr) begin
                        n_est = blpd_pkg::ST_EMPTY; n_eend = i_eof; n_state = S_ERR;
                    end else if (!i_done && i_eof) begin
                        n_est = blpd_pkg::ST_TRUNC; n_eend = 1'b1; n_state = S_ERR;
                    end else if (i_done && i_idx < IW'(HEADER_OFFSET)) begin
                        n_est = blpd_pkg::ST_EMPTY; n_eend = i_eof; n_state = S_ERR;
                    end else if (i_idx < IW'(HEADER_OFFSET)) begin
                        o_cmd.payload = 1'b1;
                    end else if (i_idx == IW'(HEADER_OFFSET)) begin
                        n_soh = i_wrap;
                        n_cnt = '0;
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_BYTE;
                    end
                end
            end
            S_FLUSH: begin
                if (emit_ok) begin
                    o_cmd.emit = 1'b1;
                    n_ov = 1'b1;
                    if (r_soh) begin
                        o_cmd.kind = blpd_pkg::K_SOH;
                        n_soh = 1'b0;
                    end else begin
                        o_cmd.kind = blpd_pkg::K_HOLD;
                        n_cnt = RW'(r_cnt + 1'b1);
                        if (r_cnt == RW'(HEADER_OFFSET - 1)) begin
                            n_state = S_BYTE;
                        end
                    end
                end
            end
            S_BYTE: begin
                if (emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = blpd_pkg::K_BYTE;
                    o_cmd.payload = 1'b1;
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                    if (i_done) begin
                        n_phase = (i_fmt == blpd_pkg::FMT_LE16) ? P_PAD : P_PREFIX;
                        if (i_wrap) begin
                            n_state = S_ETX;
                        end
                    end
                    if (i_eof) begin
                        n_phase = P_PREFIX;
                        o_cmd.clr_halt = 1'b1;
                    end
                end
            end
            S_ETX: begin
                if (emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = blpd_pkg::K_ETX;
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ERR: begin
                if (emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = blpd_pkg::K_ERROR;
                    o_cmd.status = r_est;
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                    if (r_eend) begin
                        n_phase = P_PREFIX;
                        o_cmd.clr_halt = 1'b1;
                    end else begin
                        n_halt = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_prefix <= 1'b1;
        end else if (o_cmd.prefix) begin
            r_first_prefix <= i_prefix_done;
        end else if (o_cmd.clr_halt) begin
            r_first_prefix <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_PREFIX;
            r_halt  <= 1'b0;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
            r_soh   <= 1'b0;
            r_est   <= blpd_pkg::ST_OK;
            r_eend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_halt  <= n_halt;
            r_ov    <= n_ov;
            r_cnt   <= n_cnt;
            r_soh   <= n_soh;
            r_est   <= n_est;
            r_eend  <= n_eend;
        end
    end
endmodule

/* rtl/bulletin_length_prefix_deframer.sv */
// Length-prefixed bulletin deframer: takes one file byte per item and emits
// one result item per record byte, plus status-only items for errors and
// SOH and ETX items around wrapped records. The prefix format comes from
// the frame_format register (the user must write it only while idle; the
// block does not enforce this). Each input item is latched, then evaluated;
// each result item passes through the single output register. The item that
// completes the header check replays the held bytes from the hold buffer,
// one read per cycle unless an output stall holds the controller.
module bulletin_length_prefix_deframer #(
    parameter int HEADER_OFFSET = 10,
    parameter int MAX_HEADER    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_wdata,
    // input byte channel
    input  logic                i_valid,
    output logic                o_stall,
    input  blpd_pkg::t_in_item  i_item,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output blpd_pkg::t_out_item o_item
);
    localparam int IW = $clog2(HEADER_OFFSET + 2);
    localparam int RW = $clog2(HEADER_OFFSET + 1);

    logic [2:0]     r_fmt;
    blpd_pkg::t_cmd cmd;
    logic [7:0]     dp_byte;
    logic           dp_eof, dp_pdone, dp_lzero, dp_wrap, dp_hdr, dp_done;
    logic [IW-1:0]  dp_idx;
    logic [RW-1:0]  rd_idx;

    // frame format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= blpd_pkg::FMT_LE16;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    blpd_ctrl #(.HEADER_OFFSET(HEADER_OFFSET)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fmt(r_fmt),
        .i_in_valid(i_valid), .o_in_stall(o_stall),
        .o_out_valid(o_valid), .i_out_stall(i_stall),
        .i_byte(dp_byte), .i_eof(dp_eof), .i_prefix_done(dp_pdone),
        .i_len_zero(dp_lzero), .i_wrap(dp_wrap), .i_idx(dp_idx),
        .i_hdr(dp_hdr), .i_done(dp_done), .o_cmd(cmd), .o_rd_idx(rd_idx)
    );

    blpd_datapath #(.HEADER_OFFSET(HEADER_OFFSET), .MAX_HEADER(MAX_HEADER)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fmt(r_fmt), .i_item(i_item),
        .i_cmd(cmd), .i_rd_idx(rd_idx), .o_byte(dp_byte), .o_eof(dp_eof),
        .o_prefix_done(dp_pdone), .o_len_zero(dp_lzero), .o_wrap(dp_wrap),
        .o_idx(dp_idx), .o_hdr(dp_hdr), .o_done(dp_done), .o_res(o_item)
    );
endmodule

/* dv/bulletin_length_prefix_deframer_tb.sv */
module bulletin_length_prefix_deframer_tb;

    localparam int HDR_OFS = 10;
    localparam int HDR_MAX = 25;
    localparam int PH_PREFIX = 0;
    localparam int PH_PAYLOAD = 1;
    localparam int PH_PAD = 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] FMT_BAD = 3'd7;

    // predictor of the deframer plus queue of expected result items
    class deframer_scoreboard;
        logic [2:0] fmt;
        int phase;
        int pcount;
        logic [31:0] acc;
        logic [31:0] left;
        int pidx;
        logic [7:0] hold [0:HDR_OFS];
        int hcount;
        bit hend;
        bit wrap;
        bit halted;
        int dstate;
        blpd_pkg::t_out_item pending [$];
        int errors;
        int n_checked;
        int n_errs_seen;

        function void clear();
            fmt = blpd_pkg::FMT_LE16;
            phase = PH_PREFIX;
            pcount = 0;
            acc = 0;
            left = 0;
            pidx = 0;
            hcount = 0;
            hend = 0;
            wrap = 0;
            halted = 0;
            dstate = 0;
            errors = 0;
            n_checked = 0;
            n_errs_seen = 0;
        endfunction

        function void push(bit v, logic [7:0] b, bit f, bit h, logic [7:0] hc, bit l,
                           logic [1:0] st, logic [32:0] len);
            blpd_pkg::t_out_item r;
            r.out_valid = v;
            r.out_byte = b;
            r.first_of_record = f;
            r.is_header = h;
            r.header_char = hc;
            r.last_of_record = l;
            r.status = st;
            r.record_length = len;
            pending.push_back(r);
        endfunction

        function void to_idle();
            phase = PH_PREFIX;
            pcount = 0;
            halted = 0;
        endfunction

        function void error_out(logic [1:0] st, bit eof);
            push(0, 0, 0, 0, 0, 1, st, 0);
            if (eof) to_idle();
            else halted = 1;
        endfunction

        function int prefix_size();
            if (fmt == blpd_pkg::FMT_LE16) return 2;
            if (fmt == blpd_pkg::FMT_ASCII) return 10;
            return 4;
        endfunction

        function void fold_prefix(logic [7:0] b);
            int n;
            n = pcount;
            if (n == 0) begin
                acc = 0;
                wrap = 0;
                dstate = 0;
            end
            case (fmt)
                blpd_pkg::FMT_LE16, blpd_pkg::FMT_LE32: begin
                    if (n < 4) acc = acc | (32'(b) << (8 * n));
                end
                blpd_pkg::FMT_BE32: acc = {acc[23:0], b};
                blpd_pkg::FMT_BE24: begin
                    if (n > 0) acc = {acc[23:0], b};
                end
                default: begin
                    if (n < 8) begin
                        if (dstate == 0 && b == blpd_pkg::CH_SPACE) begin
                        end else if (dstate < 2 && b >= blpd_pkg::CH_ZERO
                                     && b <= blpd_pkg::CH_NINE) begin
                            acc = acc * blpd_pkg::RADIX + 32'(b - blpd_pkg::CH_ZERO);
                            dstate = 1;
                        end else begin
                            dstate = 2;
                        end
                    end else if (n == 9) begin
                        wrap = (b == blpd_pkg::TYPE_WRAP);
                    end
                end
            endcase
            pcount = (n + 1) & 15;
        endfunction

        // one accepted input item
        function void note_input(blpd_pkg::t_in_item it);
            logic [7:0] b;
            bit eof, hdr, done, opening;
            int i0;
            logic [32:0] len;
            b = it.in_byte;
            eof = it.end_of_file;
            hdr = 0;
            if (halted) begin
                if (eof) to_idle();
                return;
            end
            if (phase == PH_PAD) begin
                to_idle();
                return;
            end
            if (phase == PH_PREFIX) begin
                if (pcount == 0 && fmt > blpd_pkg::FMT_ASCII) begin
                    halted = 1;
                    if (eof) to_idle();
                    return;
                end
                fold_prefix(b);
                if (pcount < prefix_size()) begin
                    if (eof) error_out(blpd_pkg::ST_TRUNC, 1);
                    return;
                end
                pcount = 0;
                if (acc == 0) begin
                    if (fmt == blpd_pkg::FMT_ASCII) begin
                        if (eof) to_idle();
                    end else begin
                        error_out(blpd_pkg::ST_NOSOH, eof);
                    end
                    return;
                end
                phase = PH_PAYLOAD;
                left = acc;
                pidx = 0;
                hcount = 0;
                hend = 0;
                if (eof) error_out(blpd_pkg::ST_TRUNC, 1);
                return;
            end
            i0 = pidx;
            if (i0 == 0 && !wrap && b != blpd_pkg::CH_SOH) begin
                error_out(blpd_pkg::ST_NOSOH, eof);
                return;
            end
            if (i0 >= HDR_OFS && !hend && hcount < HDR_MAX) begin
                if (b > blpd_pkg::CTRL_TOP) begin
                    hdr = 1;
                    hcount++;
                end else begin
                    hend = 1;
                end
            end
            if (i0 == HDR_OFS && !hdr) begin
                error_out(blpd_pkg::ST_EMPTY, eof);
                return;
            end
            if (left > 0) left--;
            done = (left == 0);
            if (!done && eof) begin
                error_out(blpd_pkg::ST_TRUNC, 1);
                return;
            end
            if (done && i0 < HDR_OFS) begin
                error_out(blpd_pkg::ST_EMPTY, eof);
                return;
            end
            if (i0 < HDR_OFS) begin
                hold[i0] = b;
                pidx = i0 + 1;
                return;
            end
            len = 33'(acc) + (wrap ? 33'd2 : 33'd0);
            opening = (i0 == HDR_OFS);
            if (opening) begin
                if (wrap) push(1, blpd_pkg::CH_SOH, 1, 0, 0, 0, blpd_pkg::ST_OK, 0);
                for (int k = 0; k < HDR_OFS; k++)
                    push(1, hold[k], (k == 0) && !wrap, 0, 0, 0, blpd_pkg::ST_OK, 0);
                pidx = HDR_OFS + 1;
            end
            push(1, b, 0, hdr,
                 hdr ? (b == blpd_pkg::CH_SPACE ? blpd_pkg::CH_UNDER : b) : 8'd0,
                 done && !wrap, blpd_pkg::ST_OK, (done && !wrap) ? len : 33'd0);
            if (done) begin
                if (wrap) push(1, blpd_pkg::CH_ETX, 0, 0, 0, 1, blpd_pkg::ST_OK, len);
                phase = (fmt == blpd_pkg::FMT_LE16) ? PH_PAD : PH_PREFIX;
                pcount = 0;
            end
            if (eof) to_idle();
        endfunction

        function void check_result(blpd_pkg::t_out_item got);
            blpd_pkg::t_out_item want;
            if (pending.size() == 0) begin
                $error("unexpected result item %p", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got.status != blpd_pkg::ST_OK) n_errs_seen++;
            if (got.out_valid !== want.out_valid) begin
                $error("out_valid exp %0d got %0d", want.out_valid, got.out_valid);
                errors++;
            end
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte exp %0h got %0h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.first_of_record !== want.first_of_record) begin
                $error("first_of_record exp %0d got %0d", want.first_of_record,
                       got.first_of_record);
                errors++;
            end
            if (got.is_header !== want.is_header) begin
                $error("is_header exp %0d got %0d", want.is_header, got.is_header);
                errors++;
            end
            if (got.header_char !== want.header_char) begin
                $error("header_char exp %0h got %0h", want.header_char, got.header_char);
                errors++;
            end
            if (got.last_of_record !== want.last_of_record) begin
                $error("last_of_record exp %0d got %0d", want.last_of_record,
                       got.last_of_record);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status exp %0d got %0d", want.status, got.status);
                errors++;
            end
            if (got.record_length !== want.record_length) begin
                $error("record_length exp %0d got %0d", want.record_length,
                       got.record_length);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_wdata;
    logic i_valid;
    logic o_stall;
    blpd_pkg::t_in_item i_item;
    logic o_valid;
    logic i_stall;
    blpd_pkg::t_out_item o_item;

    bulletin_length_prefix_deframer uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_item(i_item),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_item(o_item)
    );

    deframer_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int cycles;
    int n_items;

    // 12-unit clock period
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // cycle limit, guards against a hung handshake
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stall set at the falling edge, results sampled at the rising edge
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_item);
    end

    // offer one item, hold it until accepted, with random idle gaps in front
    task automatic send_byte(input logic [7:0] b, input bit eof);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_item.in_byte <= b;
        i_item.end_of_file <= eof;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input('{in_byte: b, end_of_file: eof});
        n_items++;
        @(negedge i_clk);
    endtask

    // wait until all expected results are in, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (HDR_OFS + 8) @(negedge i_clk);
    endtask

    task automatic write_format(input logic [2:0] f);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= f;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.fmt = f;
    endtask

    // length prefix for the current format
    task automatic send_prefix(input logic [31:0] len, input bit wrap_type);
        string s;
        case (sb.fmt)
            blpd_pkg::FMT_LE16: begin
                send_byte(len[7:0], 0);
                send_byte(len[15:8], 0);
            end
            blpd_pkg::FMT_LE32: for (int k = 0; k < 4; k++) send_byte(len[8*k +: 8], 0);
            blpd_pkg::FMT_BE32: for (int k = 3; k >= 0; k--) send_byte(len[8*k +: 8], 0);
            blpd_pkg::FMT_BE24: begin
                send_byte(8'($urandom), 0);
                for (int k = 2; k >= 0; k--) send_byte(len[8*k +: 8], 0);
            end
            default: begin
                s = $sformatf("%8d", len);
                for (int k = 0; k < 8; k++) send_byte(s[k], 0);
                send_byte(8'($urandom), 0);
                send_byte(wrap_type ? blpd_pkg::TYPE_WRAP : 8'($urandom_range(255, 50)), 0);
            end
        endcase
    endtask

    // well-formed record with random content; may end the file
    task automatic send_record(input int len, input bit wrap_type, input bit eof_at_end);
        logic [7:0] b;
        int hlen;
        hlen = $urandom_range(30, 1);
        send_prefix(len, wrap_type);
        for (int k = 0; k < len; k++) begin
            if (k == 0 && !wrap_type) b = blpd_pkg::CH_SOH;
            else if (k >= HDR_OFS && k < HDR_OFS + hlen)
                b = ($urandom_range(3) == 0) ? blpd_pkg::CH_SPACE
                                             : 8'($urandom_range(255, 32));
            else b = 8'($urandom);
            send_byte(b, eof_at_end && (k == len - 1) && sb.fmt != blpd_pkg::FMT_LE16);
        end
        if (sb.fmt == blpd_pkg::FMT_LE16) send_byte(8'($urandom), eof_at_end);
    endtask

    task automatic random_phase(input int n);
        int r;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(99);
            if (r < 75) begin
                send_record($urandom_range(26, 11),
                            (sb.fmt == blpd_pkg::FMT_ASCII) && $urandom_range(1),
                            $urandom_range(3) == 0);
            end else if (r < 90) begin
                // noise
                repeat ($urandom_range(6, 1)) send_byte(8'($urandom), 0);
                send_byte(8'($urandom), 1);
            end else begin
                // possibly broken record: the file may end before the record does
                send_prefix($urandom_range(40, 12), 0);
                send_byte(blpd_pkg::CH_SOH, 0);
                repeat ($urandom_range(12, 1)) send_byte(8'($urandom_range(255, 32)), 0);
                send_byte(8'hFF, 1);
            end
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        n_items = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = blpd_pkg::FMT_LE16;
        i_valid = 1'b0;
        i_item = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, sender idling less than receiver: good record with pad,
        // zero length, short payload, wrapped ascii record, ascii zero length
        send_idle_pct = 32;
        recv_idle_pct = 67;
        send_record(12, 0, 0);
        send_prefix(0, 0);
        send_byte(8'h00, 1);
        send_prefix(5, 0);
        send_byte(blpd_pkg::CH_SOH, 0);
        send_byte(8'hFF, 0);
        send_byte(8'h00, 0);
        send_byte(8'h00, 0);
        send_byte(8'h80, 1);
        write_format(blpd_pkg::FMT_ASCII);
        send_record(13, 1, 0);
        send_prefix(0, 0);
        send_byte(8'h20, 1);

        // directed, receiver idling less than sender: missing soh, bad format,
        // file-ending record, empty header
        send_idle_pct = 67;
        recv_idle_pct = 32;
        write_format(blpd_pkg::FMT_BE32);
        send_prefix(3, 0);
        send_byte(8'h7F, 1);
        send_byte(8'h01, 0);
        send_byte(8'h02, 1);
        write_format(FMT_BAD);
        send_byte(8'hAA, 1);
        write_format(blpd_pkg::FMT_BE24);
        send_record(11, 0, 1);
        write_format(blpd_pkg::FMT_LE32);
        send_prefix(11, 0);
        send_byte(blpd_pkg::CH_SOH, 0);
        repeat (9) send_byte(8'h41, 0);
        send_byte(8'h1F, 1);

        // random traffic with no idling
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_format(blpd_pkg::FMT_ASCII);
        random_phase(1);

        drain();
        $display("stimulus: %0d input items over all five formats, %0d results checked",
                 n_items, sb.n_checked);
        $display("error results seen: %0d, idling sender and receiver both ways",
                 sb.n_errs_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            if (sb.pending.size() != 0) $error("%0d results never arrived", sb.pending.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
